// ===== hw/rtl/reck_pkg.sv =====
// reck_pkg: shared widths, pipeline control type and obstacle vertex rom
// for the roadmap edge check; no dependencies
`default_nettype none

package reck_pkg;

    localparam int POLYGON_COUNT        = 2;
    localparam int VERTICES_PER_POLYGON = 4;
    localparam int COORD_BITS           = 12;

    localparam int EDGE_COUNT = POLYGON_COUNT * (VERTICES_PER_POLYGON - 1);
    localparam int RomScale   = 10;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int TURN_W = PROD_W + 1;
    localparam int D2_W   = 2 * COORD_BITS + 2;

    localparam int RADIUS_W = 25;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(2500);

    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = 8;

    // output field positions in tdata
    localparam int OUT_HIT  = 0;
    localparam int OUT_NEAR = 1;
    localparam int OUT_OK   = 2;

    // orientation codes
    localparam logic [1:0] TURN_ZERO = 2'b00;
    localparam logic [1:0] TURN_POS  = 2'b01;
    localparam logic [1:0] TURN_NEG  = 2'b10;

    // load enables of pipeline stages two to four
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_en;

    // vertex rom in whole units, scaled to tenths; unlisted entries are (0,0)
    function automatic logic [COORD_BITS-1:0] rom_x(input int pg, input int vtx);
        int u;
        u = 0;
        case (pg)
            0: begin
                case (vtx)
                    0: u = 1;
                    1: u = 5;
                    2: u = 3;
                    3: u = 1;
                    default: u = 0;
                endcase
            end
            1: begin
                case (vtx)
                    0: u = 12;
                    1: u = 13;
                    2: u = 16;
                    3: u = 12;
                    default: u = 0;
                endcase
            end
            default: u = 0;
        endcase
        return COORD_BITS'(u * RomScale);
    endfunction

    function automatic logic [COORD_BITS-1:0] rom_y(input int pg, input int vtx);
        int u;
        u = 0;
        case (pg)
            0: begin
                case (vtx)
                    0: u = 2;
                    1: u = 4;
                    2: u = 1;
                    3: u = 2;
                    default: u = 0;
                endcase
            end
            1: begin
                case (vtx)
                    0: u = 10;
                    1: u = 9;
                    2: u = 15;
                    3: u = 10;
                    default: u = 0;
                endcase
            end
            default: u = 0;
        endcase
        return COORD_BITS'(u * RomScale);
    endfunction

    // orientation code from the sign of a cross term
    function automatic logic [1:0] turn_code(input logic signed [TURN_W-1:0] v);
        logic [1:0] c;
        if (v == '0) begin
            c = TURN_ZERO;
        end else if (v[TURN_W-1]) begin
            c = TURN_NEG;
        end else begin
            c = TURN_POS;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/roadmap_edge_validity_check.sv =====
// roadmap_edge_validity_check: top level, stream ports, radius register,
// valid/ready pipeline control; uses reck_pkg, reck_edge_lane, reck_dist
`default_nettype none

// Checks one candidate roadmap edge per request against every edge of the
// built-in obstacle polygons and against the connection radius. The block
// takes one request every clock cycle while the output is not held off and
// returns one result per request, in order. A request passes through five
// register stages: input capture, coordinate differences, one multiplier
// bank per obstacle edge lane, orientation signs with the segment test, and
// the output register. Every obstacle edge has its own lane, so the rate
// does not depend on how many edges the rom holds. A stalled output backs
// the stages up one by one; nothing is dropped or repeated. The radius
// register (squared, in hundredths, reset 2500) should be written only
// while no request is in flight.

module roadmap_edge_validity_check
    import reck_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [RADIUS_W-1:0] i_cfg_wdata,   // radius_sq
    // request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // end_a_x, end_a_y, end_b_x, end_b_y
    input  wire logic [IN_W-1:0]     s_axis_tdata,
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // hits_obstacle, within_radius, edge_ok, zero pad
    output logic [OUT_W-1:0]         m_axis_tdata
);

    // valid bit per stage and the ready chain behind it
    logic [5:1] r_v;
    logic [5:1] w_rdy;
    t_pipe_en   w_en;

    logic [RADIUS_W-1:0] r_radius_sq;

    // stage 1: captured endpoints
    logic [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;

    // stage 4 results from the lanes and the distance unit
    logic [EDGE_COUNT-1:0] w_meet;
    logic w_near;

    // stage 5: output register
    logic r_hit, r_near;

    // a stage takes new data when it is empty or its contents move on
    always_comb begin
        w_rdy[5] = !r_v[5] || m_axis_tready;
        w_rdy[4] = !r_v[4] || w_rdy[5];
        w_rdy[3] = !r_v[3] || w_rdy[4];
        w_rdy[2] = !r_v[2] || w_rdy[3];
        w_rdy[1] = !r_v[1] || w_rdy[2];
        w_en.en2 = w_rdy[2];
        w_en.en3 = w_rdy[3];
        w_en.en4 = w_rdy[4];
    end

    assign s_axis_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) r_v[1] <= s_axis_tvalid;
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
            if (w_rdy[4]) r_v[4] <= r_v[3];
            if (w_rdy[5]) r_v[5] <= r_v[4];
        end
    end

    // radius register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius_sq <= i_cfg_wdata;
        end
    end

    // input capture, fields packed from the low bits up
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_ax <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
            r_ay <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
            r_bx <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
            r_by <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        end
    end

    // one lane per obstacle edge: vertex i to vertex i+1 of each polygon
    for (genvar pg = 0; pg < POLYGON_COUNT; pg++) begin : g_poly
        for (genvar vtx = 0; vtx < VERTICES_PER_POLYGON - 1; vtx++) begin : g_edge
            reck_edge_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_ax   (r_ax),
                .i_ay   (r_ay),
                .i_bx   (r_bx),
                .i_by   (r_by),
                .i_sx   (rom_x(pg, vtx)),
                .i_sy   (rom_y(pg, vtx)),
                .i_ex   (rom_x(pg, vtx + 1)),
                .i_ey   (rom_y(pg, vtx + 1)),
                .o_meet (w_meet[pg * (VERTICES_PER_POLYGON - 1) + vtx])
            );
        end
    end

    reck_dist u_dist (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_ax        (r_ax),
        .i_ay        (r_ay),
        .i_bx        (r_bx),
        .i_by        (r_by),
        .i_radius_sq (r_radius_sq),
        .o_near      (w_near)
    );

    // stage 5: any lane hit flags the edge
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_hit  <= |w_meet;
            r_near <= w_near;
        end
    end

    assign m_axis_tvalid = r_v[5];

    always_comb begin
        m_axis_tdata           = '0;
        m_axis_tdata[OUT_HIT]  = r_hit;
        m_axis_tdata[OUT_NEAR] = r_near;
        m_axis_tdata[OUT_OK]   = r_near && !r_hit;
    end

    // an output that is free or being taken lets a new request in
    a_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("request refused while the pipeline drains");

    // a held output must not cost the item waiting behind it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && m_axis_tvalid && !m_axis_tready) |=> (r_v[4] && m_axis_tvalid))
        else $error("item lost in stage four under stall");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== hw/rtl/reck_edge_lane.sv =====
// reck_edge_lane: segment intersection test of the candidate edge against
// one fixed obstacle edge, pipeline stages two to four; uses reck_pkg
`default_nettype none

module reck_edge_lane
    import reck_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_pipe_en              i_en,
    input  wire logic [COORD_BITS-1:0] i_ax,
    input  wire logic [COORD_BITS-1:0] i_ay,
    input  wire logic [COORD_BITS-1:0] i_bx,
    input  wire logic [COORD_BITS-1:0] i_by,
    input  wire logic [COORD_BITS-1:0] i_sx,
    input  wire logic [COORD_BITS-1:0] i_sy,
    input  wire logic [COORD_BITS-1:0] i_ex,
    input  wire logic [COORD_BITS-1:0] i_ey,
    output logic                       o_meet
);

    // stage 2: differences and bounding box flags
    logic signed [DIFF_W-1:0] r_bay, r_bax, r_sbx, r_sby, r_ebx, r_eby;
    logic signed [DIFF_W-1:0] r_aex, r_aey, r_bex, r_bey, r_esx, r_esy;
    logic [3:0] r_box2, r_box3;

    // stage 3: products
    logic signed [PROD_W-1:0] r_p1a, r_p1b, r_p2a, r_p2b;
    logic signed [PROD_W-1:0] r_p3a, r_p3b, r_p4a, r_p4b;

    logic [COORD_BITS-1:0] w_abx_hi, w_abx_lo, w_aby_hi, w_aby_lo;
    logic [COORD_BITS-1:0] w_sex_hi, w_sex_lo, w_sey_hi, w_sey_lo;
    logic [3:0] w_box;
    logic signed [TURN_W-1:0] w_t1, w_t2, w_t3, w_t4;
    logic [1:0] w_c1, w_c2, w_c3, w_c4;
    logic w_meet;

    function automatic logic signed [DIFF_W-1:0] sub(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    always_comb begin
        w_abx_hi = (i_ax > i_bx) ? i_ax : i_bx;
        w_abx_lo = (i_ax > i_bx) ? i_bx : i_ax;
        w_aby_hi = (i_ay > i_by) ? i_ay : i_by;
        w_aby_lo = (i_ay > i_by) ? i_by : i_ay;
        w_sex_hi = (i_sx > i_ex) ? i_sx : i_ex;
        w_sex_lo = (i_sx > i_ex) ? i_ex : i_sx;
        w_sey_hi = (i_sy > i_ey) ? i_sy : i_ey;
        w_sey_lo = (i_sy > i_ey) ? i_ey : i_sy;
        // s in box of a-b, e in box of a-b, a in box of s-e, b in box of s-e
        w_box[0] = (i_sx <= w_abx_hi) && (i_sx >= w_abx_lo) &&
                   (i_sy <= w_aby_hi) && (i_sy >= w_aby_lo);
        w_box[1] = (i_ex <= w_abx_hi) && (i_ex >= w_abx_lo) &&
                   (i_ey <= w_aby_hi) && (i_ey >= w_aby_lo);
        w_box[2] = (i_ax <= w_sex_hi) && (i_ax >= w_sex_lo) &&
                   (i_ay <= w_sey_hi) && (i_ay >= w_sey_lo);
        w_box[3] = (i_bx <= w_sex_hi) && (i_bx >= w_sex_lo) &&
                   (i_by <= w_sey_hi) && (i_by >= w_sey_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_bay  <= sub(i_by, i_ay);
            r_bax  <= sub(i_bx, i_ax);
            r_sbx  <= sub(i_sx, i_bx);
            r_sby  <= sub(i_sy, i_by);
            r_ebx  <= sub(i_ex, i_bx);
            r_eby  <= sub(i_ey, i_by);
            r_aex  <= sub(i_ax, i_ex);
            r_aey  <= sub(i_ay, i_ey);
            r_bex  <= sub(i_bx, i_ex);
            r_bey  <= sub(i_by, i_ey);
            r_esx  <= sub(i_ex, i_sx);
            r_esy  <= sub(i_ey, i_sy);
            r_box2 <= w_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_p1a  <= r_bay * r_sbx;
            r_p1b  <= r_bax * r_sby;
            r_p2a  <= r_bay * r_ebx;
            r_p2b  <= r_bax * r_eby;
            r_p3a  <= r_esy * r_aex;
            r_p3b  <= r_esx * r_aey;
            r_p4a  <= r_esy * r_bex;
            r_p4b  <= r_esx * r_bey;
            r_box3 <= r_box2;
        end
    end

    always_comb begin
        w_t1 = TURN_W'(r_p1a) - TURN_W'(r_p1b);
        w_t2 = TURN_W'(r_p2a) - TURN_W'(r_p2b);
        w_t3 = TURN_W'(r_p3a) - TURN_W'(r_p3b);
        w_t4 = TURN_W'(r_p4a) - TURN_W'(r_p4b);
        w_c1 = turn_code(w_t1);
        w_c2 = turn_code(w_t2);
        w_c3 = turn_code(w_t3);
        w_c4 = turn_code(w_t4);
        // general crossing, or an endpoint collinear and on the other segment
        w_meet = ((w_c1 != w_c2) && (w_c3 != w_c4)) ||
                 ((w_c1 == TURN_ZERO) && r_box3[0]) ||
                 ((w_c2 == TURN_ZERO) && r_box3[1]) ||
                 ((w_c3 == TURN_ZERO) && r_box3[2]) ||
                 ((w_c4 == TURN_ZERO) && r_box3[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            o_meet <= w_meet;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/reck_dist.sv =====
// reck_dist: squared endpoint distance against the radius register,
// pipeline stages two to four; uses reck_pkg
`default_nettype none

module reck_dist
    import reck_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_pipe_en              i_en,
    input  wire logic [COORD_BITS-1:0] i_ax,
    input  wire logic [COORD_BITS-1:0] i_ay,
    input  wire logic [COORD_BITS-1:0] i_bx,
    input  wire logic [COORD_BITS-1:0] i_by,
    input  wire logic [RADIUS_W-1:0]   i_radius_sq,
    output logic                       o_near
);

    localparam int CMP_W = (D2_W > RADIUS_W) ? D2_W : RADIUS_W;

    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [PROD_W-1:0] r_sqx, r_sqy;
    logic [D2_W-1:0] w_d2;

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_dx <= $signed({1'b0, i_ax}) - $signed({1'b0, i_bx});
            r_dy <= $signed({1'b0, i_ay}) - $signed({1'b0, i_by});
        end
        if (i_en.en3) begin
            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
        end
    end

    // squares are never negative and each fits below the sign bit
    assign w_d2 = D2_W'(unsigned'(r_sqx)) + D2_W'(unsigned'(r_sqy));

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            o_near <= CMP_W'(w_d2) <= CMP_W'(i_radius_sq);
        end
    end

endmodule

`default_nettype wire
